// ===== sv/ios_pkg.sv =====
// Shared types and constants for the indexed operand stack.
package ios_pkg;

    localparam int IOS_STACK_DEPTH  = 1024;
    localparam int IOS_OBJECT_WIDTH = 64;

    localparam int MODE_W      = 3;
    localparam int INDEX_W     = 10;
    localparam int VALUE_W     = 64;
    localparam int DEPTH_NOW_W = 11;
    localparam int STATUS_W    = 2;

    localparam int S_FIELDS_W = INDEX_W + VALUE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = VALUE_W + DEPTH_NOW_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = MODE_W;
    localparam int M_TUSER_W  = STATUS_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 3'd0,
        MODE_POP    = 3'd1,
        MODE_RD_TOP = 3'd2,
        MODE_RD_BOT = 3'd3,
        MODE_WR_TOP = 3'd4,
        MODE_WR_BOT = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_RANGE     = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // What travels with an operation while its memory read is in flight.
    typedef struct packed {
        logic                   use_ram;
        status_t                status;
        logic [DEPTH_NOW_W-1:0] depth_now;
    } ios_stage_t;

endpackage

// ===== sv/ios_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module ios_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/indexed_operand_stack.sv =====
// An accepted beat is registered in the p1 stage, then in the output register (m_tvalid).
// Throughput: one operation per cycle while the output is free; each operation makes at
// most one access to the one-port object RAM at its accept edge, read out when p1 moves on.
// Reset (aresetn low, synchronous): depth and empty value clear to zero, pipeline empties.
// The object RAM is not cleared; entries are defined once pushed.
module indexed_operand_stack
    import ios_pkg::*;
#(
    parameter int STACK_DEPTH  = IOS_STACK_DEPTH,
    parameter int OBJECT_WIDTH = IOS_OBJECT_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration: empty_value.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [VALUE_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // index[9:0], write_value[73:10], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,  // mode[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // read_value[63:0], depth_now[74:64], zero pad
    output logic [M_TUSER_W-1:0] m_tuser   // status[1:0]
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int CW = (DW > INDEX_W) ? DW : INDEX_W;

    logic [DW-1:0]           depth_reg, depth_next, depth_dec;
    logic [OBJECT_WIDTH-1:0] empty_reg;
    logic                    p1_valid_reg;
    ios_stage_t              p1_reg, stage_c;
    logic                    m_valid_reg;
    logic [VALUE_W-1:0]      m_value_reg;
    logic [DEPTH_NOW_W-1:0]  m_depth_reg;
    status_t                 m_status_reg;

    logic                    acc, out_free;
    mode_t                   op;
    logic [CW-1:0]           idx_ext, dep_ext, pos_top;
    logic                    in_range;
    logic [OBJECT_WIDTH-1:0] wval, ram_rdata;
    logic                    ram_en, ram_we;
    logic [AW-1:0]           ram_addr;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = !p1_valid_reg || out_free;
    assign acc       = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign op        = mode_t'(s_tuser[MODE_W-1:0]);
    assign idx_ext   = CW'(s_tdata[INDEX_W-1:0]);
    assign dep_ext   = CW'(depth_reg);
    assign pos_top   = dep_ext - idx_ext - CW'(1);
    assign in_range  = idx_ext < dep_ext;
    assign wval      = s_tdata[INDEX_W +: OBJECT_WIDTH];
    assign depth_dec = depth_reg - DW'(1);

    always_comb begin
        depth_next      = depth_reg;
        ram_en          = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = '0;
        stage_c.use_ram = 1'b0;
        stage_c.status  = ST_OK;
        case (op)
            MODE_PUSH: begin
                if (depth_reg == DW'(STACK_DEPTH)) begin
                    stage_c.status = ST_OVERFLOW;
                end else begin
                    ram_en     = 1'b1;
                    ram_we     = 1'b1;
                    ram_addr   = depth_reg[AW-1:0];
                    depth_next = depth_reg + DW'(1);
                end
            end
            MODE_POP: begin
                if (depth_reg == '0) begin
                    stage_c.status = ST_UNDERFLOW;
                end else begin
                    ram_en          = 1'b1;
                    ram_addr        = depth_dec[AW-1:0];
                    depth_next      = depth_dec;
                    stage_c.use_ram = 1'b1;
                end
            end
            MODE_RD_TOP, MODE_RD_BOT, MODE_WR_TOP, MODE_WR_BOT: begin
                if (!in_range) begin
                    stage_c.status = ST_RANGE;
                end else begin
                    ram_en = 1'b1;
                    if (op == MODE_RD_TOP || op == MODE_WR_TOP) begin
                        ram_addr = pos_top[AW-1:0];
                    end else begin
                        ram_addr = idx_ext[AW-1:0];
                    end
                    if (op == MODE_WR_TOP || op == MODE_WR_BOT) begin
                        ram_we = 1'b1;
                    end else begin
                        stage_c.use_ram = 1'b1;
                    end
                end
            end
            default: begin
                // Unused modes change nothing and report ok.
            end
        endcase
        stage_c.depth_now = DEPTH_NOW_W'(depth_next);
    end

    // A write and a later read of the same entry never share an edge, since
    // every operation touches the RAM at most once, at its own accept edge.
    ios_ram #(
        .WIDTH (OBJECT_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en && acc),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wval),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg    <= '0;
            empty_reg    <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                empty_reg <= cfg_data[OBJECT_WIDTH-1:0];
            end
            if (acc) begin
                depth_reg <= depth_next;
            end
            if (s_tready) begin
                p1_valid_reg <= s_tvalid;
            end
            if (p1_valid_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The RAM read data holds while the stage is stalled, because no new
    // beat is accepted then.
    always_ff @(posedge aclk) begin
        if (acc) begin
            p1_reg <= stage_c;
        end
        if (p1_valid_reg && out_free) begin
            m_value_reg  <= VALUE_W'(p1_reg.use_ram ? ram_rdata : empty_reg);
            m_depth_reg  <= p1_reg.depth_now;
            m_status_reg <= p1_reg.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, m_depth_reg, m_value_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ===== sv/ios_checker.sv =====
// Port-level assertions for the indexed operand stack, bound to the top level.
module ios_checker
    import ios_pkg::*;
#(
    parameter int STACK_DEPTH = IOS_STACK_DEPTH
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [VALUE_W-1:0]   cfg_data,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    logic [DEPTH_NOW_W-1:0] depth_now;
    logic                   unused_ok;

    assign depth_now = m_tdata[VALUE_W +: DEPTH_NOW_W];
    assign unused_ok = cfg_valid ^ cfg_ready ^ (^cfg_data) ^ s_tvalid ^ s_tready
                     ^ (^s_tdata) ^ (^s_tuser);

    // A refused push can only come from a full stack.
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_OVERFLOW |-> depth_now == DEPTH_NOW_W'(STACK_DEPTH))
        else $error("overflow reported below full depth");

    // An underflow can only come from an empty stack.
    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_UNDERFLOW |-> depth_now == '0)
        else $error("underflow reported with objects held");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind indexed_operand_stack ios_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (.*);

// ===== test/tb.sv =====
// Self-checking testbench for the indexed operand stack: directed and random ops vs. a behavioral stack.
module tb;
    import ios_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 8;

    // Mode codes that the block must ignore.
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } stack_op_t;

    typedef struct {
        logic [VALUE_W-1:0]     read_value;
        logic [DEPTH_NOW_W-1:0] depth_now;
        status_t                status;
    } stack_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [VALUE_W-1:0]   cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Behavioral copy of the stack contents and settings.
    logic [VALUE_W-1:0]     model_store [IOS_STACK_DEPTH];
    logic [DEPTH_NOW_W-1:0] model_depth = '0;
    logic [VALUE_W-1:0]     model_empty = '0;

    stack_op_t     pending_ops[$];
    stack_result_t expected_results[$];
    stack_op_t     cur_op;

    int  gen_depth       = 0;
    int  send_gap        = 0;
    int  stall_left      = 0;
    bit  long_hold_req   = 1'b0;
    bit  calm            = 1'b0;
    int  ops_accepted    = 0;
    int  results_checked = 0;
    int  mismatches      = 0;
    int  cfg_writes      = 0;
    int  peak_depth      = 0;
    int  cycles          = 0;
    int  status_seen [4] = '{0, 0, 0, 0};

    indexed_operand_stack u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Applies one operation to the behavioral stack and returns what the block should report.
    function automatic stack_result_t execute_stack_op(stack_op_t op);
        stack_result_t          r;
        logic [DEPTH_NOW_W-1:0] pos;
        r.read_value = model_empty;
        r.status     = ST_OK;
        case (op.mode)
            MODE_PUSH: begin
                if (model_depth >= IOS_STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    model_store[model_depth] = op.value;
                    model_depth++;
                end
            end
            MODE_POP: begin
                if (model_depth == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    model_depth--;
                    r.read_value = model_store[model_depth];
                end
            end
            MODE_RD_TOP, MODE_RD_BOT, MODE_WR_TOP, MODE_WR_BOT: begin
                if (op.index >= model_depth) begin
                    r.status = ST_RANGE;
                end else begin
                    pos = (op.mode == MODE_RD_TOP || op.mode == MODE_WR_TOP) ?
                          model_depth - 11'd1 - op.index : DEPTH_NOW_W'(op.index);
                    if (op.mode == MODE_RD_TOP || op.mode == MODE_RD_BOT)
                        r.read_value = model_store[pos];
                    else
                        model_store[pos] = op.value;
                end
            end
            default: ;
        endcase
        r.depth_now = model_depth;
        if (model_depth > peak_depth)
            peak_depth = model_depth;
        status_seen[r.status]++;
        return r;
    endfunction

    function automatic void queue_op(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] index,
                                     logic [VALUE_W-1:0] value);
        stack_op_t op;
        op.mode  = mode;
        op.index = index;
        op.value = value;
        pending_ops.push_back(op);
        if (mode == MODE_PUSH && gen_depth < IOS_STACK_DEPTH)
            gen_depth++;
        else if (mode == MODE_POP && gen_depth > 0)
            gen_depth--;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly in-range indexes, with the first out-of-range position and the full field mixed in.
    function automatic logic [INDEX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 9);
        if (gen_depth > 0 && r < 7)
            return INDEX_W'($urandom_range(0, gen_depth - 1));
        else if (r == 7)
            return INDEX_W'(gen_depth);
        return INDEX_W'($urandom_range(0, 1023));
    endfunction

    function automatic void queue_random_op(int push_w, int pop_w, int other_w);
        int                r;
        logic [MODE_W-1:0] mode;
        r = $urandom_range(0, push_w + pop_w + other_w - 1);
        if (r < push_w) begin
            mode = MODE_PUSH;
        end else if (r < push_w + pop_w) begin
            mode = MODE_POP;
        end else begin
            case ($urandom_range(0, 8))
                0, 1:    mode = MODE_RD_TOP;
                2, 3:    mode = MODE_RD_BOT;
                4, 5:    mode = MODE_WR_TOP;
                6, 7:    mode = MODE_WR_BOT;
                default: mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
            endcase
        end
        queue_op(mode, pick_index(), random_value());
    endfunction

    task automatic write_empty_value(input logic [VALUE_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_empty = v;
        cfg_writes++;
    endtask

    // The sender holds back here until every queued operation has been answered.
    task automatic wait_idle();
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Input side: one beat at a time from the pending queue, with random gaps outside the calm phase.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(execute_stack_op(cur_op));
                ops_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 13);
                    s_tvalid <= 1'b0;
                end else begin
                    cur_op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, cur_op.value, cur_op.index};
                    s_tuser  <= cur_op.mode;
                end
            end
        end
    end

    // Output side: check each result beat against the oldest expectation; random stalls unless calm.
    always @(posedge aclk) begin : result_check
        stack_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no operation outstanding: tdata=%h tuser=%h",
                           m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (m_tdata[VALUE_W-1:0] !== want.read_value) begin
                        $error("read_value: expected %h, actual %h",
                               want.read_value, m_tdata[VALUE_W-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[VALUE_W +: DEPTH_NOW_W] !== want.depth_now) begin
                        $error("depth_now: expected %0d, actual %0d",
                               want.depth_now, m_tdata[VALUE_W +: DEPTH_NOW_W]);
                        mismatches++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                // Long hold-off so the pipeline backs up and the input side stalls.
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int i;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        write_empty_value({$urandom, $urandom});
        // Directed: failures on an empty stack, ignored modes, then a small stack.
        queue_op(MODE_POP,     10'd0,    random_value());
        queue_op(MODE_RD_TOP,  10'd0,    random_value());
        queue_op(MODE_RD_BOT,  10'd0,    random_value());
        queue_op(MODE_WR_TOP,  10'd0,    random_value());
        queue_op(MODE_WR_BOT,  10'd0,    random_value());
        queue_op(MODE_SPARE_A, 10'd1023, '1);
        queue_op(MODE_SPARE_B, 10'd0,    '0);
        queue_op(MODE_PUSH,    10'd1023, '1);
        queue_op(MODE_PUSH,    10'd0,    '0);
        queue_op(MODE_PUSH,    10'd0,    {$urandom, $urandom});
        queue_op(MODE_PUSH,    10'd0,    64'h8000_0000_0000_0001);
        queue_op(MODE_RD_TOP,  10'd0,    '0);
        queue_op(MODE_RD_TOP,  10'd3,    '0);
        queue_op(MODE_RD_TOP,  10'd4,    '0);
        queue_op(MODE_RD_BOT,  10'd0,    '0);
        queue_op(MODE_RD_BOT,  10'd3,    '0);
        queue_op(MODE_RD_BOT,  10'd1023, '0);
        queue_op(MODE_WR_TOP,  10'd0,    {$urandom, $urandom});
        queue_op(MODE_WR_BOT,  10'd0,    {$urandom, $urandom});
        queue_op(MODE_WR_TOP,  10'd1023, '1);
        queue_op(MODE_RD_TOP,  10'd0,    '0);
        queue_op(MODE_RD_BOT,  10'd0,    '0);
        for (i = 0; i < 5; i++)
            queue_op(MODE_POP, 10'd0, '0);
        wait_idle();

        write_empty_value('1);
        for (i = 0; i < 400; i++)
            queue_random_op(35, 25, 40);
        long_hold_req = 1'b1;
        wait_idle();

        // Fill to capacity, then work at the full boundary.
        write_empty_value('0);
        while (gen_depth < IOS_STACK_DEPTH)
            queue_random_op(90, 0, 10);
        for (i = 0; i < 3; i++)
            queue_op(MODE_PUSH, 10'd0, random_value());
        queue_op(MODE_RD_TOP, 10'd1023, '0);
        queue_op(MODE_RD_BOT, 10'd1023, '0);
        queue_op(MODE_WR_TOP, 10'd1023, random_value());
        queue_op(MODE_WR_BOT, 10'd1023, random_value());
        queue_op(MODE_RD_TOP, 10'd0,    '0);
        queue_op(MODE_RD_BOT, 10'd0,    '0);
        for (i = 0; i < 150; i++)
            queue_random_op(30, 30, 40);
        wait_idle();

        write_empty_value({$urandom, $urandom});
        calm = 1'b1;
        for (i = 0; i < 300; i++)
            queue_random_op(30, 30, 40);
        wait_idle();

        $display("Ran %0d operations, checked %0d results, peak depth %0d, %0d empty-value writes.",
                 ops_accepted, results_checked, peak_depth, cfg_writes);
        $display("Status counts ok/underflow/range/overflow: %0d/%0d/%0d/%0d.",
                 status_seen[ST_OK], status_seen[ST_UNDERFLOW], status_seen[ST_RANGE],
                 status_seen[ST_OVERFLOW]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ios_pkg.sv
sv/ios_ram.sv
sv/indexed_operand_stack.sv
sv/ios_checker.sv
test/tb.sv
